@@ rtl/aarm_pkg.sv @@
`default_nettype none

package aarm_pkg;

   // CORDIC datapath width: Q30 values plus headroom for the rotation gain.
   localparam int CordicWidth = 34;

   // Angle word width: binary angle units where pi is 2^31.
   localparam int AngleWidth = 32;

   // Depth of the arctangent table; the step index wraps at this depth.
   localparam int AtanDepth = 32;

   // Starting x value: the inverse CORDIC gain in Q30.
   localparam logic signed [CordicWidth-1:0] InvGainQ30 = 34'sd652032874;

   // Quarter and half turn in binary angle units.
   localparam logic signed [CordicWidth-1:0] HalfPi = 34'sd1073741824;
   localparam logic signed [CordicWidth-1:0] FullPi = 34'sd2147483648;

   // Control that travels with each request along the chain.
   typedef struct packed {
      logic valid;
      logic flip;
   } cordic_ctl_type;

   // atan(2^-i) in binary angle units where pi is 2^31.
   function automatic logic [29:0] atan_lookup(input logic [4:0] idx);
      logic [29:0] val;
      case (idx)
         5'd0: val = 30'd536870912;
         5'd1: val = 30'd316933406;
         5'd2: val = 30'd167458907;
         5'd3: val = 30'd85004756;
         5'd4: val = 30'd42667331;
         5'd5: val = 30'd21354465;
         5'd6: val = 30'd10680862;
         5'd7: val = 30'd5340245;
         5'd8: val = 30'd2670163;
         5'd9: val = 30'd1335087;
         5'd10: val = 30'd667544;
         5'd11: val = 30'd333772;
         5'd12: val = 30'd166886;
         5'd13: val = 30'd83443;
         5'd14: val = 30'd41722;
         5'd15: val = 30'd20861;
         5'd16: val = 30'd10430;
         5'd17: val = 30'd5215;
         5'd18: val = 30'd2608;
         5'd19: val = 30'd1304;
         5'd20: val = 30'd652;
         5'd21: val = 30'd326;
         5'd22: val = 30'd163;
         5'd23: val = 30'd81;
         5'd24: val = 30'd41;
         5'd25: val = 30'd20;
         5'd26: val = 30'd10;
         5'd27: val = 30'd5;
         5'd28: val = 30'd3;
         5'd29: val = 30'd1;
         5'd30: val = 30'd1;
         default: val = 30'd0;
      endcase
      return val;
   endfunction

endpackage

`default_nettype wire

@@ rtl/aarm_if.sv @@
`default_nettype none

// Request channel: one rotation axis and one angle.
interface aarm_req_if #(parameter int DATA_WIDTH = 16);
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] axis_x;
   logic signed [DATA_WIDTH-1:0] axis_y;
   logic signed [DATA_WIDTH-1:0] axis_z;
   logic signed [DATA_WIDTH-1:0] angle;

   modport source (output valid, output axis_x, output axis_y, output axis_z,
                   output angle, input ready);
   modport sink (input valid, input axis_x, input axis_y, input axis_z,
                 input angle, output ready);
endinterface

// Response channel: the nine entries of the rotation matrix.
interface aarm_rsp_if #(parameter int DATA_WIDTH = 16);
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] r00;
   logic signed [DATA_WIDTH-1:0] r01;
   logic signed [DATA_WIDTH-1:0] r02;
   logic signed [DATA_WIDTH-1:0] r10;
   logic signed [DATA_WIDTH-1:0] r11;
   logic signed [DATA_WIDTH-1:0] r12;
   logic signed [DATA_WIDTH-1:0] r20;
   logic signed [DATA_WIDTH-1:0] r21;
   logic signed [DATA_WIDTH-1:0] r22;

   modport source (output valid, output r00, output r01, output r02,
                   output r10, output r11, output r12, output r20,
                   output r21, output r22, input ready);
   modport sink (input valid, input r00, input r01, input r02, input r10,
                 input r11, input r12, input r20, input r21, input r22,
                 output ready);
endinterface

`default_nettype wire

@@ rtl/aarm_cordic_cell.sv @@
`default_nettype none

// One CORDIC rotation step. Each cell registers its result and hands it to
// the next cell; the axis rides along unchanged.
module aarm_cordic_cell #(
   parameter int DATA_WIDTH = 16,
   parameter int STEP       = 0
) (
   input  wire                                       clock,
   input  wire                                       reset,
   input  wire                                       advance,
   input  wire aarm_pkg::cordic_ctl_type             prev_ctl,
   input  wire signed [aarm_pkg::CordicWidth-1:0]    prev_x,
   input  wire signed [aarm_pkg::CordicWidth-1:0]    prev_y,
   input  wire signed [aarm_pkg::CordicWidth-1:0]    prev_z,
   input  wire        [3*DATA_WIDTH-1:0]             prev_axis,
   output aarm_pkg::cordic_ctl_type                  next_ctl,
   output logic signed [aarm_pkg::CordicWidth-1:0]   next_x,
   output logic signed [aarm_pkg::CordicWidth-1:0]   next_y,
   output logic signed [aarm_pkg::CordicWidth-1:0]   next_z,
   output logic       [3*DATA_WIDTH-1:0]             next_axis
);

   localparam int CW = aarm_pkg::CordicWidth;
   localparam logic [4:0] Idx = 5'(STEP % aarm_pkg::AtanDepth);

   aarm_pkg::cordic_ctl_type ctl_ff;
   logic signed [CW-1:0]     x_ff, x_in;
   logic signed [CW-1:0]     y_ff, y_in;
   logic signed [CW-1:0]     z_ff, z_in;
   logic [3*DATA_WIDTH-1:0]  axis_ff;
   logic signed [CW-1:0]     dx, dy, rot;

   // Rotate toward zero residual angle.
   always_comb begin
      dx  = prev_y >>> Idx;
      dy  = prev_x >>> Idx;
      rot = signed'(CW'(aarm_pkg::atan_lookup(Idx)));
      if (!prev_z[CW-1]) begin
         x_in = prev_x - dx;
         y_in = prev_y + dy;
         z_in = prev_z - rot;
      end else begin
         x_in = prev_x + dx;
         y_in = prev_y - dy;
         z_in = prev_z + rot;
      end
   end

   // Control register.
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (advance) begin
         ctl_ff <= prev_ctl;
      end
   end

   // Data registers.
   always_ff @(posedge clock) begin
      if (advance) begin
         x_ff    <= x_in;
         y_ff    <= y_in;
         z_ff    <= z_in;
         axis_ff <= prev_axis;
      end
   end

   assign next_ctl  = ctl_ff;
   assign next_x    = x_ff;
   assign next_y    = y_ff;
   assign next_z    = z_ff;
   assign next_axis = axis_ff;

endmodule

`default_nettype wire

@@ rtl/aarm_matrix.sv @@
`default_nettype none

// Rodrigues' formula on the CORDIC result, in four register stages:
// round cosine and sine and form the axis products, then one minus cosine and
// the sine terms, then the scaled outer products, then the nine entries.
module aarm_matrix #(
   parameter int DATA_WIDTH = 16
) (
   input  wire                                     clock,
   input  wire                                     reset,
   input  wire                                     advance,
   input  wire aarm_pkg::cordic_ctl_type           cord_ctl,
   input  wire signed [aarm_pkg::CordicWidth-1:0]  cord_x,
   input  wire signed [aarm_pkg::CordicWidth-1:0]  cord_y,
   input  wire        [3*DATA_WIDTH-1:0]           cord_axis,
   output logic                                    out_valid,
   output logic signed [DATA_WIDTH-1:0]            entry [9]
);

   localparam int W         = DATA_WIDTH;
   localparam int Frac      = W - 2;
   localparam int CW        = aarm_pkg::CordicWidth;
   localparam int RoundBits = aarm_pkg::AngleWidth - W;
   localparam logic signed [CW:0] RoundHalf =
      (CW+1)'((35'sd1 <<< RoundBits) >>> 1);
   localparam logic signed [2*W-1:0] ProdHalf = (2*W)'(1) <<< (Frac - 1);
   localparam logic signed [W:0] OneQ = (W+1)'(1) <<< Frac;

   // Clamp a double-width product to W bits.
   function automatic logic signed [W-1:0] sat_prod(input logic signed [2*W-1:0] v);
      logic signed [W-1:0] res;
      if (v[2*W-1:W-1] == {(W+1){v[2*W-1]}}) begin
         res = v[W-1:0];
      end else begin
         res = {v[2*W-1], {(W-1){~v[2*W-1]}}};
      end
      return res;
   endfunction

   // Clamp a sum with one carry bit to W bits.
   function automatic logic signed [W-1:0] sat_sum(input logic signed [W:0] v);
      logic signed [W-1:0] res;
      if (v[W] == v[W-1]) begin
         res = v[W-1:0];
      end else begin
         res = {v[W], {(W-1){~v[W]}}};
      end
      return res;
   endfunction

   // Clamp a rounded CORDIC word to W bits.
   function automatic logic signed [W-1:0] sat_cord(input logic signed [CW:0] v);
      logic signed [W-1:0] res;
      if (v[CW:W-1] == {(CW-W+2){v[CW]}}) begin
         res = v[W-1:0];
      end else begin
         res = {v[CW], {(W-1){~v[CW]}}};
      end
      return res;
   endfunction

   // Fixed-point product with round half up and saturation.
   function automatic logic signed [W-1:0] qmul(input logic signed [W-1:0] a,
                                               input logic signed [W-1:0] b);
      logic signed [2*W-1:0] p;
      p = a * b;
      p = p + ProdHalf;
      return sat_prod(p >>> Frac);
   endfunction

   // Round a Q30 CORDIC output, after the sign fold, down to W bits.
   function automatic logic signed [W-1:0] round_cord(input logic signed [CW-1:0] v,
                                                     input logic flip);
      logic signed [CW:0] e;
      e = (CW+1)'(v);
      if (flip) begin
         e = -e;
      end
      e = e + RoundHalf;
      return sat_cord(e >>> RoundBits);
   endfunction

   logic signed [W-1:0] kx, ky, kz;

   // Stage A: cosine, sine and axis products.
   logic                va_ff;
   logic signed [W-1:0] c_a_ff, s_a_ff;
   logic signed [W-1:0] kx_a_ff, ky_a_ff, kz_a_ff;
   logic signed [W-1:0] kxx_a_ff, kyy_a_ff, kzz_a_ff, kxy_a_ff, kxz_a_ff, kyz_a_ff;

   // Stage B: one minus cosine and sine terms.
   logic                vb_ff;
   logic signed [W-1:0] c_b_ff, omc_b_ff, kxs_b_ff, kys_b_ff, kzs_b_ff;
   logic signed [W-1:0] kxx_b_ff, kyy_b_ff, kzz_b_ff, kxy_b_ff, kxz_b_ff, kyz_b_ff;

   // Stage C: scaled outer products.
   logic                vc_ff;
   logic signed [W-1:0] c_c_ff, kxs_c_ff, kys_c_ff, kzs_c_ff;
   logic signed [W-1:0] pxx_c_ff, pyy_c_ff, pzz_c_ff, pxy_c_ff, pxz_c_ff, pyz_c_ff;

   // Stage D: output register.
   logic                vd_ff;
   logic signed [W-1:0] r_ff [9];
   logic signed [W-1:0] r_in [9];

   assign kx = signed'(cord_axis[3*W-1:2*W]);
   assign ky = signed'(cord_axis[2*W-1:W]);
   assign kz = signed'(cord_axis[W-1:0]);

   // Valid bits of the four stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
         vd_ff <= 1'b0;
      end else if (advance) begin
         va_ff <= cord_ctl.valid;
         vb_ff <= va_ff;
         vc_ff <= vb_ff;
         vd_ff <= vc_ff;
      end
   end

   // Stage A data.
   always_ff @(posedge clock) begin
      if (advance) begin
         c_a_ff   <= round_cord(cord_x, cord_ctl.flip);
         s_a_ff   <= round_cord(cord_y, cord_ctl.flip);
         kx_a_ff  <= kx;
         ky_a_ff  <= ky;
         kz_a_ff  <= kz;
         kxx_a_ff <= qmul(kx, kx);
         kyy_a_ff <= qmul(ky, ky);
         kzz_a_ff <= qmul(kz, kz);
         kxy_a_ff <= qmul(kx, ky);
         kxz_a_ff <= qmul(kx, kz);
         kyz_a_ff <= qmul(ky, kz);
      end
   end

   // Stage B data.
   always_ff @(posedge clock) begin
      if (advance) begin
         c_b_ff   <= c_a_ff;
         omc_b_ff <= sat_sum(OneQ - (W+1)'(c_a_ff));
         kxs_b_ff <= qmul(kx_a_ff, s_a_ff);
         kys_b_ff <= qmul(ky_a_ff, s_a_ff);
         kzs_b_ff <= qmul(kz_a_ff, s_a_ff);
         kxx_b_ff <= kxx_a_ff;
         kyy_b_ff <= kyy_a_ff;
         kzz_b_ff <= kzz_a_ff;
         kxy_b_ff <= kxy_a_ff;
         kxz_b_ff <= kxz_a_ff;
         kyz_b_ff <= kyz_a_ff;
      end
   end

   // Stage C data.
   always_ff @(posedge clock) begin
      if (advance) begin
         c_c_ff   <= c_b_ff;
         kxs_c_ff <= kxs_b_ff;
         kys_c_ff <= kys_b_ff;
         kzs_c_ff <= kzs_b_ff;
         pxx_c_ff <= qmul(kxx_b_ff, omc_b_ff);
         pyy_c_ff <= qmul(kyy_b_ff, omc_b_ff);
         pzz_c_ff <= qmul(kzz_b_ff, omc_b_ff);
         pxy_c_ff <= qmul(kxy_b_ff, omc_b_ff);
         pxz_c_ff <= qmul(kxz_b_ff, omc_b_ff);
         pyz_c_ff <= qmul(kyz_b_ff, omc_b_ff);
      end
   end

   // Matrix entries with the cross-product signs of Rodrigues' formula.
   always_comb begin
      r_in[0] = sat_sum((W+1)'(c_c_ff) + (W+1)'(pxx_c_ff));
      r_in[1] = sat_sum((W+1)'(pxy_c_ff) - (W+1)'(kzs_c_ff));
      r_in[2] = sat_sum((W+1)'(pxz_c_ff) + (W+1)'(kys_c_ff));
      r_in[3] = sat_sum((W+1)'(pxy_c_ff) + (W+1)'(kzs_c_ff));
      r_in[4] = sat_sum((W+1)'(c_c_ff) + (W+1)'(pyy_c_ff));
      r_in[5] = sat_sum((W+1)'(pyz_c_ff) - (W+1)'(kxs_c_ff));
      r_in[6] = sat_sum((W+1)'(pxz_c_ff) - (W+1)'(kys_c_ff));
      r_in[7] = sat_sum((W+1)'(pyz_c_ff) + (W+1)'(kxs_c_ff));
      r_in[8] = sat_sum((W+1)'(c_c_ff) + (W+1)'(pzz_c_ff));
   end

   // Stage D data.
   always_ff @(posedge clock) begin
      if (advance) begin
         r_ff <= r_in;
      end
   end

   assign out_valid = vd_ff;
   assign entry     = r_ff;

endmodule

`default_nettype wire

@@ rtl/axis_angle_to_rotation_matrix.sv @@
`default_nettype none

// Axis-angle to rotation matrix. Each request carries a unit axis in signed
// Q2.(DATA_WIDTH-2) and an angle in binary units (the full word spans -pi to
// pi and wraps); each response carries the nine entries of the 3x3 rotation
// matrix in the same Q format, saturated. The block accepts one request per
// clock while the output is not stalled; each response passes the angle fold
// register, one register for each cell of the CORDIC row (one rotation per
// cell), and the register stages of Rodrigues' formula. The whole pipeline
// holds while a finished response waits at the output register. There is no
// configuration and no state between requests.
module axis_angle_to_rotation_matrix #(
   parameter int DATA_WIDTH   = 16,
   parameter int CORDIC_STEPS = 16
) (
   input  wire          clock,
   input  wire          reset,
   aarm_req_if.sink     req_chan,
   aarm_rsp_if.source   rsp_chan
);

   localparam int W  = DATA_WIDTH;
   localparam int CW = aarm_pkg::CordicWidth;
   localparam int AngleShift = aarm_pkg::AngleWidth - W;

   logic advance;
   logic out_valid;
   logic signed [W-1:0] entry [9];

   // Angle fold registers.
   aarm_pkg::cordic_ctl_type fold_ctl_ff, fold_ctl_in;
   logic signed [CW-1:0]     fold_z_ff, fold_z_in;
   logic [3*W-1:0]           fold_axis_ff;
   logic signed [aarm_pkg::AngleWidth-1:0] z_scaled;
   logic signed [CW-1:0]     z_wide;

   // Chain links between the CORDIC cells.
   aarm_pkg::cordic_ctl_type ctl_chain  [CORDIC_STEPS+1];
   logic signed [CW-1:0]     x_chain    [CORDIC_STEPS+1];
   logic signed [CW-1:0]     y_chain    [CORDIC_STEPS+1];
   logic signed [CW-1:0]     z_chain    [CORDIC_STEPS+1];
   logic [3*W-1:0]           axis_chain [CORDIC_STEPS+1];

   // The pipeline moves whenever the output register is free or being read.
   assign advance        = !out_valid || rsp_chan.ready;
   assign req_chan.ready = advance;

   // Scale the angle to pi = 2^31 and fold it into [-pi/2, pi/2].
   always_comb begin
      z_scaled = aarm_pkg::AngleWidth'(req_chan.angle) <<< AngleShift;
      z_wide   = CW'(z_scaled);
      fold_ctl_in.valid = req_chan.valid;
      fold_ctl_in.flip  = 1'b0;
      fold_z_in         = z_wide;
      if (z_wide > aarm_pkg::HalfPi) begin
         fold_z_in        = z_wide - aarm_pkg::FullPi;
         fold_ctl_in.flip = 1'b1;
      end else if (z_wide < -aarm_pkg::HalfPi) begin
         fold_z_in        = z_wide + aarm_pkg::FullPi;
         fold_ctl_in.flip = 1'b1;
      end
   end

   // Fold stage control.
   always_ff @(posedge clock) begin
      if (reset) begin
         fold_ctl_ff <= '0;
      end else if (advance) begin
         fold_ctl_ff <= fold_ctl_in;
      end
   end

   // Fold stage data.
   always_ff @(posedge clock) begin
      if (advance) begin
         fold_z_ff    <= fold_z_in;
         fold_axis_ff <= {req_chan.axis_x, req_chan.axis_y, req_chan.axis_z};
      end
   end

   // The row starts from the inverse gain on the x axis.
   assign ctl_chain[0]  = fold_ctl_ff;
   assign x_chain[0]    = aarm_pkg::InvGainQ30;
   assign y_chain[0]    = '0;
   assign z_chain[0]    = fold_z_ff;
   assign axis_chain[0] = fold_axis_ff;

   // Row of CORDIC cells.
   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
      aarm_cordic_cell #(
         .DATA_WIDTH (W),
         .STEP       (i)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .prev_ctl  (ctl_chain[i]),
         .prev_x    (x_chain[i]),
         .prev_y    (y_chain[i]),
         .prev_z    (z_chain[i]),
         .prev_axis (axis_chain[i]),
         .next_ctl  (ctl_chain[i+1]),
         .next_x    (x_chain[i+1]),
         .next_y    (y_chain[i+1]),
         .next_z    (z_chain[i+1]),
         .next_axis (axis_chain[i+1])
      );
   end

   // Rodrigues' formula and output register.
   aarm_matrix #(
      .DATA_WIDTH (W)
   ) u_matrix (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .cord_ctl  (ctl_chain[CORDIC_STEPS]),
      .cord_x    (x_chain[CORDIC_STEPS]),
      .cord_y    (y_chain[CORDIC_STEPS]),
      .cord_axis (axis_chain[CORDIC_STEPS]),
      .out_valid (out_valid),
      .entry     (entry)
   );

   assign rsp_chan.valid = out_valid;
   assign rsp_chan.r00   = entry[0];
   assign rsp_chan.r01   = entry[1];
   assign rsp_chan.r02   = entry[2];
   assign rsp_chan.r10   = entry[3];
   assign rsp_chan.r11   = entry[4];
   assign rsp_chan.r12   = entry[5];
   assign rsp_chan.r20   = entry[6];
   assign rsp_chan.r21   = entry[7];
   assign rsp_chan.r22   = entry[8];

`ifndef SYNTH
   // A stalled fold stage keeps its angle.
   a_fold_holds: assert property (@(posedge clock) disable iff (reset)
      (fold_ctl_ff.valid && !advance) |=> $stable(fold_z_ff))
      else $error("fold stage changed while stalled");

   // No request is taken while a finished response waits.
   a_no_take_on_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.ready) |-> !req_chan.ready)
      else $error("request accepted while the output is stalled");

   // Reset empties the pipeline.
   a_reset_clears: assert property (@(posedge clock)
      $past(reset) |-> !rsp_chan.valid)
      else $error("response valid right after reset");
`endif

endmodule

`default_nettype wire

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

   localparam int DATA_WIDTH   = 16;
   localparam int CORDIC_STEPS = 16;
   localparam int FRAC         = DATA_WIDTH - 2;
   localparam int ONE_Q        = 1 << FRAC;
   localparam int LATENCY      = CORDIC_STEPS + 5;
   localparam int MAX_IDLE     = 14;
   localparam int RANDOM_COUNT = 1850;

   // One request as queued for the driver, with its lead-in gap.
   typedef struct {
      logic signed [DATA_WIDTH-1:0] axis_x;
      logic signed [DATA_WIDTH-1:0] axis_y;
      logic signed [DATA_WIDTH-1:0] axis_z;
      logic signed [DATA_WIDTH-1:0] angle;
      int                           gap;
      bit                           drain;
   } request_t;

   // Nine matrix entries, index = row * 3 + column.
   typedef logic [8:0][DATA_WIDTH-1:0] matrix_t;

   logic clock;
   logic reset;

   aarm_req_if #(.DATA_WIDTH(DATA_WIDTH)) req_bus ();
   aarm_rsp_if #(.DATA_WIDTH(DATA_WIDTH)) rsp_bus ();

   axis_angle_to_rotation_matrix #(
      .DATA_WIDTH  (DATA_WIDTH),
      .CORDIC_STEPS(CORDIC_STEPS)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_bus),
      .rsp_chan(rsp_bus)
   );

   request_t pending_q[$];
   matrix_t  expected_q[$];
   request_t in_flight;
   int       total_requests;
   int       accepted_count;
   int       mismatch_count;
   int       idle_left;
   bit       gap_armed;
   int       stall_left;
   bit       sink_burst;

   // Arctangent of 2^-k in binary angle units where pi is 2^31.
   function automatic longint atan_step(input int k);
      case (k)
         0: return 536870912;   1: return 316933406;   2: return 167458907;
         3: return 85004756;    4: return 42667331;    5: return 21354465;
         6: return 10680862;    7: return 5340245;     8: return 2670163;
         9: return 1335087;     10: return 667544;     11: return 333772;
         12: return 166886;     13: return 83443;      14: return 41722;
         15: return 20861;      16: return 10430;      17: return 5215;
         18: return 2608;       19: return 1304;       20: return 652;
         21: return 326;        22: return 163;        23: return 81;
         24: return 41;         25: return 20;         26: return 10;
         27: return 5;          28: return 3;          29: return 1;
         30: return 1;
         default: return 0;
      endcase
   endfunction

   // Clamp to the signed range of one entry.
   function automatic longint clamp_entry(input longint v);
      longint hi;
      longint lo;
      hi = (longint'(1) <<< (DATA_WIDTH - 1)) - 1;
      lo = -(longint'(1) <<< (DATA_WIDTH - 1));
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
   endfunction

   // Round half up while dropping sh fraction bits.
   function automatic longint round_drop(input longint v, input int sh);
      if (sh == 0) return v;
      return (v + (longint'(1) <<< (sh - 1))) >>> sh;
   endfunction

   function automatic longint fixed_mul(input longint a, input longint b);
      return clamp_entry(round_drop(a * b, FRAC));
   endfunction

   // Rotation matrix for one axis and angle: CORDIC cosine and sine, then
   // Rodrigues' formula with saturation on every product and entry.
   function automatic matrix_t rotation_of(input request_t q);
      longint  z, x, y, dx, dy, c, s, omc;
      longint  kx, ky, kz, kxs, kys, kzs, pxy, pxz, pyz;
      longint  e [9];
      bit      flip;
      int      k;
      matrix_t m;
      kx = longint'(q.axis_x);
      ky = longint'(q.axis_y);
      kz = longint'(q.axis_z);
      z = longint'(q.angle) * (longint'(1) <<< (32 - DATA_WIDTH));
      x = 652032874;
      y = 0;
      flip = 1'b0;
      // Fold the angle into the CORDIC's convergence range.
      if (z > (longint'(1) <<< 30)) begin
         z = z - (longint'(1) <<< 31);
         flip = 1'b1;
      end else if (z < -(longint'(1) <<< 30)) begin
         z = z + (longint'(1) <<< 31);
         flip = 1'b1;
      end
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         k = i % 32;
         dx = y >>> k;
         dy = x >>> k;
         if (z >= 0) begin
            x = x - dx;
            y = y + dy;
            z = z - atan_step(k);
         end else begin
            x = x + dx;
            y = y - dy;
            z = z + atan_step(k);
         end
      end
      if (flip) begin
         x = -x;
         y = -y;
      end
      c = clamp_entry(round_drop(x, 30 - FRAC));
      s = clamp_entry(round_drop(y, 30 - FRAC));
      omc = clamp_entry(longint'(ONE_Q) - c);
      kxs = fixed_mul(kx, s);
      kys = fixed_mul(ky, s);
      kzs = fixed_mul(kz, s);
      pxy = fixed_mul(fixed_mul(kx, ky), omc);
      pxz = fixed_mul(fixed_mul(kx, kz), omc);
      pyz = fixed_mul(fixed_mul(ky, kz), omc);
      e[0] = clamp_entry(c + fixed_mul(fixed_mul(kx, kx), omc));
      e[1] = clamp_entry(pxy - kzs);
      e[2] = clamp_entry(pxz + kys);
      e[3] = clamp_entry(pxy + kzs);
      e[4] = clamp_entry(c + fixed_mul(fixed_mul(ky, ky), omc));
      e[5] = clamp_entry(pyz - kxs);
      e[6] = clamp_entry(pxz - kys);
      e[7] = clamp_entry(pyz + kxs);
      e[8] = clamp_entry(c + fixed_mul(fixed_mul(kz, kz), omc));
      for (int j = 0; j < 9; j++) m[j] = e[j][DATA_WIDTH-1:0];
      return m;
   endfunction

   task automatic add_request(input int ax, input int ay, input int az, input int ang,
                              input int gap, input bit drain);
      request_t r;
      r.axis_x = ax[DATA_WIDTH-1:0];
      r.axis_y = ay[DATA_WIDTH-1:0];
      r.axis_z = az[DATA_WIDTH-1:0];
      r.angle  = ang[DATA_WIDTH-1:0];
      r.gap    = gap;
      r.drain  = drain;
      pending_q.push_back(r);
   endtask

   // Clock.
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Run limit, far beyond the slowest legal run.
   initial begin
      #8_000_000;
      $display("Some tests failed");
      $finish;
   end

   // Request driver: presents queued requests, honoring each one's gap and
   // holding a drain-marked request until every matrix has come back.
   always @(posedge clock) begin : request_driver
      request_t nxt;
      bit       present;
      if (reset) begin
         req_bus.valid <= 1'b0;
         idle_left = 0;
         gap_armed = 1'b0;
      end else begin
         present = req_bus.valid;
         if (req_bus.valid && req_bus.ready) begin
            expected_q.push_back(rotation_of(in_flight));
            accepted_count++;
            present = 1'b0;
         end
         if (!present && pending_q.size() != 0) begin
            if (!gap_armed) begin
               idle_left = pending_q[0].gap;
               gap_armed = 1'b1;
            end
            if (idle_left != 0) begin
               idle_left--;
            end else if (!pending_q[0].drain || expected_q.size() == 0) begin
               nxt = pending_q.pop_front();
               in_flight = nxt;
               gap_armed = 1'b0;
               present = 1'b1;
               req_bus.axis_x <= nxt.axis_x;
               req_bus.axis_y <= nxt.axis_y;
               req_bus.axis_z <= nxt.axis_z;
               req_bus.angle  <= nxt.angle;
            end
         end
         req_bus.valid <= present;
      end
   end

   // Result monitor: checks each matrix against the oldest prediction and
   // stalls ready at random, with occasional stretches of no stalling.
   always @(posedge clock) begin : result_monitor
      matrix_t want;
      matrix_t got;
      bit      rdy;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got[0] = rsp_bus.r00;
            got[1] = rsp_bus.r01;
            got[2] = rsp_bus.r02;
            got[3] = rsp_bus.r10;
            got[4] = rsp_bus.r11;
            got[5] = rsp_bus.r12;
            got[6] = rsp_bus.r20;
            got[7] = rsp_bus.r21;
            got[8] = rsp_bus.r22;
            if (expected_q.size() == 0) begin
               if (mismatch_count < 10)
                  $display("ERROR: matrix with no request outstanding at %0t", $realtime);
               mismatch_count++;
            end else begin
               want = expected_q.pop_front();
               for (int j = 0; j < 9; j++) begin
                  if (got[j] !== want[j]) begin
                     if (mismatch_count < 10)
                        $display("ERROR: r%0d%0d expected %0d got %0d at %0t", j / 3, j % 3,
                                 $signed(want[j]), $signed(got[j]), $realtime);
                     mismatch_count++;
                  end
               end
            end
            if ($urandom_range(0, 39) == 0) sink_burst = !sink_burst;
            stall_left = sink_burst ? 0 : $urandom_range(0, MAX_IDLE);
         end
         if (stall_left != 0) begin
            stall_left--;
            rdy = 1'b0;
         end else begin
            rdy = 1'b1;
         end
         rsp_bus.ready <= rdy;
      end
   end

   // Stimulus and end of run.
   initial begin
      real vx, vy, vz, norm;
      int  ax, ay, az, ang, gap, pick;
      bit  src_burst;
      reset = 1'b1;
      req_bus.valid  = 1'b0;
      req_bus.axis_x = '0;
      req_bus.axis_y = '0;
      req_bus.axis_z = '0;
      req_bus.angle  = '0;
      rsp_bus.ready  = 1'b0;
      accepted_count = 0;
      mismatch_count = 0;
      sink_burst = 1'b0;
      src_burst = 1'b0;

      // Directed requests: unit axes, the fold boundaries at +/- pi/2, the
      // angle of -pi, extreme axes where products saturate, and zero axes.
      add_request(ONE_Q, 0, 0, 0, 0, 0);
      add_request(0, ONE_Q, 0, 8192, 0, 0);
      add_request(0, 0, ONE_Q, 16384, 0, 0);
      add_request(0, 0, ONE_Q, 16385, 3, 0);
      add_request(ONE_Q, 0, 0, -16384, 0, 0);
      add_request(0, ONE_Q, 0, -16385, 0, 0);
      add_request(0, 0, -ONE_Q, -32768, 5, 0);
      add_request(-ONE_Q, 0, 0, 32767, 0, 0);
      add_request(9459, 9459, 9459, 12000, 0, 0);
      add_request(0, 0, 0, 5000, 1, 0);
      add_request(32767, 32767, 32767, 32767, 0, 0);
      add_request(-32768, -32768, -32768, -32768, 0, 0);
      add_request(32767, -32768, 32767, 16384, 0, 0);
      add_request(-32768, 32767, -32768, -8192, 2, 0);
      add_request(32767, 0, 0, 1, 0, 0);
      add_request(0, -32768, 0, -1, 0, 0);
      add_request(ONE_Q, ONE_Q, ONE_Q, 21845, 0, 0);
      add_request(0, 0, 0, 0, 0, 0);
      add_request(11585, 11585, 0, -21845, 0, 1);
      add_request(0, 11585, -11585, 32000, 0, 0);

      // Random requests: mostly unit axes, some arbitrary words, some signed
      // one-hot axes; angles mostly uniform, some at the fold edges or near zero.
      for (int i = 0; i < RANDOM_COUNT; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            vx = real'($urandom_range(0, 2000)) - 1000.0;
            vy = real'($urandom_range(0, 2000)) - 1000.0;
            vz = real'($urandom_range(0, 2000)) - 1000.0;
            norm = $sqrt(vx * vx + vy * vy + vz * vz);
            if (norm < 1.0) begin
               vx = 1.0;
               norm = 1.0;
            end
            ax = $rtoi(vx / norm * real'(ONE_Q) + ((vx >= 0.0) ? 0.5 : -0.5));
            ay = $rtoi(vy / norm * real'(ONE_Q) + ((vy >= 0.0) ? 0.5 : -0.5));
            az = $rtoi(vz / norm * real'(ONE_Q) + ((vz >= 0.0) ? 0.5 : -0.5));
         end else if (pick < 85) begin
            ax = $signed($urandom() & 32'hFFFF);
            ay = $signed($urandom() & 32'hFFFF);
            az = $signed($urandom() & 32'hFFFF);
         end else begin
            ax = 0;
            ay = 0;
            az = 0;
            case ($urandom_range(0, 2))
               0: ax = $urandom_range(0, 1) ? ONE_Q : -ONE_Q;
               1: ay = $urandom_range(0, 1) ? ONE_Q : -ONE_Q;
               default: az = $urandom_range(0, 1) ? ONE_Q : -ONE_Q;
            endcase
         end
         if ($urandom_range(0, 99) < 80) begin
            ang = $urandom() & 32'hFFFF;
         end else begin
            case ($urandom_range(0, 4))
               0: ang = -32768 + $urandom_range(0, 3);
               1: ang = 16384 + $urandom_range(0, 4) - 2;
               2: ang = -16384 + $urandom_range(0, 4) - 2;
               3: ang = 32767 - $urandom_range(0, 3);
               default: ang = $urandom_range(0, 4) - 2;
            endcase
         end
         if ($urandom_range(0, 29) == 0) src_burst = !src_burst;
         gap = src_burst ? 0 : $urandom_range(0, MAX_IDLE);
         add_request(ax, ay, az, ang, gap, (i == 600) || (i == 1300));
      end
      total_requests = pending_q.size();

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (accepted_count < total_requests) @(posedge clock);
      while (expected_q.size() != 0) @(posedge clock);
      repeat (LATENCY + 20) @(posedge clock);

      if (mismatch_count == 0 && expected_q.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
